@@ rtl/ssms_pkg.sv @@
// Shared widths, constants and saturation helpers for the seek steering core.
`timescale 1ns / 1ps
`default_nettype none
package ssms_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CFG_W   = 31;
    localparam int unsigned DT_W    = 16;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned IN_W    = 24;
    localparam int unsigned OUT_W   = 192;

    localparam logic [CFG_W-1:0] MOVE_SPEED_RST   = 31'd6553600;
    localparam logic [CFG_W-1:0] MAX_VELOCITY_RST = 31'd13107200;
    localparam logic [CFG_W-1:0] MAX_STEERING_RST = 31'd3276800;

    localparam logic [1:0] REG_MOVE_SPEED   = 2'd0;
    localparam logic [1:0] REG_MAX_VELOCITY = 2'd1;
    localparam logic [1:0] REG_MAX_STEERING = 2'd2;

    // Saturate a 34-bit two's complement value to 32 bits.
    function automatic logic [VAL_W-1:0] sat34(input logic [33:0] v);
        logic [VAL_W-1:0] r;
        begin
            if (!v[33] && (v[32:31] != 2'b00)) begin
                r = 32'h7FFF_FFFF;
            end else if (v[33] && (v[32:31] != 2'b11)) begin
                r = 32'h8000_0000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
    function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/seek_steering_motion_step_core.sv @@
// Seek steering step: two length clamps and four time products on shared serial units.
`timescale 1ns / 1ps
`default_nettype none
// Every product runs on a shift-add multiplier one bit a cycle, the length takes a
// bit-pair square root, each quotient a restoring divider. One word is in flight at
// a time, so a new word is taken only once the core is back in idle; the result
// register frees the input.
// Reset (aresetn low, synchronous) zeroes position and velocity and loads the
// register defaults.
module seek_steering_motion_step_core
    import ssms_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // key_up, key_down, key_left, key_right, time_step[15:0], zero pad
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // pos_x, pos_y, vel_x, vel_y, steer_x, steer_y (32 bits each)
    output logic [OUT_W-1:0]       m_tdata,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQY  = 4'd2;
    localparam logic [3:0] ST_SQL  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_MX   = 4'd5;
    localparam logic [3:0] ST_DX   = 4'd6;
    localparam logic [3:0] ST_MY   = 4'd7;
    localparam logic [3:0] ST_DY   = 4'd8;
    localparam logic [3:0] ST_DIFF = 4'd9;
    localparam logic [3:0] ST_TSX  = 4'd10;
    localparam logic [3:0] ST_TSY  = 4'd11;
    localparam logic [3:0] ST_TVX  = 4'd12;
    localparam logic [3:0] ST_TVY  = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    logic [3:0]        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              phase_reg;
    logic [CFG_W-1:0]  move_speed_reg, max_velocity_reg, max_steering_reg;
    logic [VAL_W-1:0]  pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [VAL_W-1:0]  cx_reg, cy_reg, qx_reg, root_reg, mul_a_reg;
    logic [CFG_W-1:0]  lim_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [63:0]       p_reg, sum_reg;
    logic [34:0]       rem_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [CNT_W-1:0]  n_iter;
    logic              in_init, in_last;
    logic [VAL_W-1:0]  ax, ay;
    logic [32:0]       msum;
    logic [34:0]       sq_sh, sq_trial;
    logic [32:0]       dv_sh;
    logic              dv_ge;
    logic [VAL_W-1:0]  tmag;
    logic [33:0]       tsigned;
    logic              tneg;
    logic [VAL_W-1:0]  tbase;
    logic [VAL_W-1:0]  dx_w, dy_w;
    logic [VAL_W-1:0]  qsel;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        case (state_reg)
            ST_DX, ST_DY: n_iter = 7'd64;
            default:      n_iter = 7'd32;
        endcase
    end

    assign in_init = (cnt_reg == 7'd0);
    assign in_last = (cnt_reg == n_iter + 7'd1);

    assign ax = mag32(cx_reg);
    assign ay = mag32(cy_reg);

    // One bit of the shift-add multiplier.
    assign msum = {1'b0, p_reg[63:32]} + (p_reg[0] ? {1'b0, mul_a_reg} : 33'd0);

    // One bit of the square root: bring down two radicand bits, try root:01.
    assign sq_sh    = {rem_reg[32:0], sum_reg[63:62]};
    assign sq_trial = {1'b0, root_reg, 2'b01};

    // One bit of the restoring divider.
    assign dv_sh = {rem_reg[31:0], p_reg[63]};
    assign dv_ge = (dv_sh >= {1'b0, root_reg});

    // Finish of v*dt >> 16, floored; magnitude form rounds up for negative v.
    always_comb begin
        case (state_reg)
            ST_TSX:  begin tneg = cx_reg[31];    tbase = vel_x_reg; end
            ST_TSY:  begin tneg = cy_reg[31];    tbase = vel_y_reg; end
            ST_TVX:  begin tneg = vel_x_reg[31]; tbase = pos_x_reg; end
            default: begin tneg = vel_y_reg[31]; tbase = pos_y_reg; end
        endcase
        tmag = p_reg[47:16] + {31'd0, (tneg && (p_reg[15:0] != 16'd0))};
        tsigned = {tbase[31], tbase[31], tbase}
                  + (tneg ? (34'd0 - {2'b00, tmag}) : {2'b00, tmag});
    end

    always_comb begin
        if (s_tdata[3] && !s_tdata[2]) begin
            dx_w = {1'b0, move_speed_reg};
        end else if (s_tdata[2] && !s_tdata[3]) begin
            dx_w = 32'd0 - {1'b0, move_speed_reg};
        end else begin
            dx_w = 32'd0;
        end
        if (s_tdata[1] && !s_tdata[0]) begin
            dy_w = {1'b0, move_speed_reg};
        end else if (s_tdata[0] && !s_tdata[1]) begin
            dy_w = 32'd0 - {1'b0, move_speed_reg};
        end else begin
            dy_w = 32'd0;
        end
    end

    assign qsel = p_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            phase_reg        <= 1'b0;
            move_speed_reg   <= MOVE_SPEED_RST;
            max_velocity_reg <= MAX_VELOCITY_RST;
            max_steering_reg <= MAX_STEERING_RST;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            vel_x_reg        <= '0;
            vel_y_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MOVE_SPEED:   move_speed_reg   <= cfg_wdata;
                    REG_MAX_VELOCITY: max_velocity_reg <= cfg_wdata;
                    REG_MAX_STEERING: max_steering_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // Drop the word once taken, unless a new one is loaded this cycle.
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg    <= dx_w;
                        cy_reg    <= dy_w;
                        lim_reg   <= max_velocity_reg;
                        dt_reg    <= s_tdata[19:4];
                        phase_reg <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX, ST_SQY, ST_SQL, ST_MX, ST_MY,
                ST_TSX, ST_TSY, ST_TVX, ST_TVY: begin
                    if (in_init) begin
                        cnt_reg <= 7'd1;
                        case (state_reg)
                            ST_SQX: begin mul_a_reg <= ax; p_reg <= {32'd0, ax}; end
                            ST_SQY: begin mul_a_reg <= ay; p_reg <= {32'd0, ay}; end
                            ST_SQL: begin
                                mul_a_reg <= {1'b0, lim_reg};
                                p_reg     <= {33'd0, lim_reg};
                            end
                            ST_MX: begin mul_a_reg <= ax; p_reg <= {33'd0, lim_reg}; end
                            ST_MY: begin mul_a_reg <= ay; p_reg <= {33'd0, lim_reg}; end
                            ST_TSX: begin mul_a_reg <= ax; p_reg <= {48'd0, dt_reg}; end
                            ST_TSY: begin mul_a_reg <= ay; p_reg <= {48'd0, dt_reg}; end
                            ST_TVX: begin
                                mul_a_reg <= mag32(vel_x_reg);
                                p_reg     <= {48'd0, dt_reg};
                            end
                            default: begin
                                mul_a_reg <= mag32(vel_y_reg);
                                p_reg     <= {48'd0, dt_reg};
                            end
                        endcase
                    end else if (!in_last) begin
                        p_reg   <= {msum, p_reg[31:1]};
                        cnt_reg <= cnt_reg + 7'd1;
                    end else begin
                        cnt_reg <= '0;
                        case (state_reg)
                            ST_SQX: begin
                                sum_reg   <= p_reg;
                                state_reg <= ST_SQY;
                            end
                            ST_SQY: begin
                                sum_reg   <= sum_reg + p_reg;
                                state_reg <= ST_SQL;
                            end
                            ST_SQL: begin
                                if (sum_reg <= p_reg) begin
                                    state_reg <= phase_reg ? ST_TSX : ST_DIFF;
                                end else begin
                                    state_reg <= ST_SQRT;
                                end
                            end
                            ST_MX: state_reg <= ST_DX;
                            ST_MY: state_reg <= ST_DY;
                            ST_TSX: begin
                                vel_x_reg <= sat34(tsigned);
                                state_reg <= ST_TSY;
                            end
                            ST_TSY: begin
                                vel_y_reg <= sat34(tsigned);
                                state_reg <= ST_TVX;
                            end
                            ST_TVX: begin
                                pos_x_reg <= sat34(tsigned);
                                state_reg <= ST_TVY;
                            end
                            default: begin
                                pos_y_reg <= sat34(tsigned);
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    if (in_init) begin
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= 7'd1;
                    end else if (!in_last) begin
                        if (sq_sh >= sq_trial) begin
                            rem_reg  <= sq_sh - sq_trial;
                            root_reg <= {root_reg[30:0], 1'b1};
                        end else begin
                            rem_reg  <= sq_sh;
                            root_reg <= {root_reg[30:0], 1'b0};
                        end
                        sum_reg <= {sum_reg[61:0], 2'b00};
                        cnt_reg <= cnt_reg + 7'd1;
                    end else begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MX;
                    end
                end
                ST_DX, ST_DY: begin
                    if (in_init) begin
                        rem_reg <= '0;
                        cnt_reg <= 7'd1;
                    end else if (!in_last) begin
                        rem_reg <= {2'b00, (dv_ge ? (dv_sh - {1'b0, root_reg}) : dv_sh)};
                        p_reg   <= {p_reg[62:0], dv_ge};
                        cnt_reg <= cnt_reg + 7'd1;
                    end else begin
                        cnt_reg <= '0;
                        if (state_reg == ST_DX) begin
                            qx_reg    <= qsel;
                            state_reg <= ST_MY;
                        end else begin
                            // Apply the signs; magnitudes truncate toward zero.
                            cx_reg    <= cx_reg[31] ? (32'd0 - qx_reg) : qx_reg;
                            cy_reg    <= cy_reg[31] ? (32'd0 - qsel) : qsel;
                            state_reg <= phase_reg ? ST_TSX : ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    cx_reg <= sat34({cx_reg[31], cx_reg[31], cx_reg}
                                    - {vel_x_reg[31], vel_x_reg[31], vel_x_reg});
                    cy_reg <= sat34({cy_reg[31], cy_reg[31], cy_reg}
                                    - {vel_y_reg[31], vel_y_reg[31], vel_y_reg});
                    lim_reg   <= max_steering_reg;
                    phase_reg <= 1'b1;
                    cnt_reg   <= '0;
                    state_reg <= ST_SQX;
                end
                ST_OUT: begin
                    // Hold until the result register is free.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {cy_reg, cx_reg, vel_y_reg, vel_x_reg,
                                         pos_y_reg, pos_x_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sim/seek_steering_motion_step_core_tb.sv @@
// Self-checking testbench for the seek steering motion step core.
`timescale 1ns / 1ps
`default_nettype none
module seek_steering_motion_step_core_tb;
    import ssms_pkg::*;

    typedef struct packed {
        logic [31:0] steer_y;
        logic [31:0] steer_x;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } motion_t;

    class motion_scoreboard;
        logic [30:0] move_speed, max_vel, max_steer;
        longint pos_x, pos_y, vel_x, vel_y;
        motion_t pending[$];
        int errors;

        function void reset_state();
            move_speed = MOVE_SPEED_RST;
            max_vel = MAX_VELOCITY_RST;
            max_steer = MAX_STEERING_RST;
            pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
            errors = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void limit_length(inout longint x, inout longint y, input logic [30:0] lim);
            longint unsigned ax, ay, sum, l, len;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            l = lim;
            sum = ax * ax + ay * ay;
            if (sum <= l * l) return;
            len = root(sum);
            if (len == 0) return;
            x = (x < 0) ? -longint'((ax * l) / len) : longint'((ax * l) / len);
            y = (y < 0) ? -longint'((ay * l) / len) : longint'((ay * l) / len);
        endfunction

        // floor((v * dt) / 2^16)
        function longint times_dt(longint v, logic [15:0] dt);
            return (v * longint'({48'd0, dt})) >>> 16;
        endfunction

        function void write_reg(logic [1:0] idx, logic [30:0] val);
            if (idx == REG_MOVE_SPEED) move_speed = val;
            else if (idx == REG_MAX_VELOCITY) max_vel = val;
            else if (idx == REG_MAX_STEERING) max_steer = val;
        endfunction

        function void note_input(logic [23:0] w);
            longint dx, dy, sx, sy, ms;
            motion_t e;
            ms = move_speed;
            dx = (longint'(w[3]) - longint'(w[2])) * ms;
            dy = (longint'(w[1]) - longint'(w[0])) * ms;
            limit_length(dx, dy, max_vel);
            sx = sat(dx - vel_x);
            sy = sat(dy - vel_y);
            limit_length(sx, sy, max_steer);
            sx = sat(sx);
            sy = sat(sy);
            vel_x = sat(vel_x + times_dt(sx, w[19:4]));
            vel_y = sat(vel_y + times_dt(sy, w[19:4]));
            pos_x = sat(pos_x + times_dt(vel_x, w[19:4]));
            pos_y = sat(pos_y + times_dt(vel_y, w[19:4]));
            e.pos_x = pos_x[31:0]; e.pos_y = pos_y[31:0];
            e.vel_x = vel_x[31:0]; e.vel_y = vel_y[31:0];
            e.steer_x = sx[31:0]; e.steer_y = sy[31:0];
            pending.push_back(e);
        endfunction

        function void check_result(motion_t got);
            motion_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.pos_x !== e.pos_x)
                $display("%0t: pos_x expected %h got %h", $time, e.pos_x, got.pos_x);
            if (got.pos_y !== e.pos_y)
                $display("%0t: pos_y expected %h got %h", $time, e.pos_y, got.pos_y);
            if (got.vel_x !== e.vel_x)
                $display("%0t: vel_x expected %h got %h", $time, e.vel_x, got.vel_x);
            if (got.vel_y !== e.vel_y)
                $display("%0t: vel_y expected %h got %h", $time, e.vel_y, got.vel_y);
            if (got.steer_x !== e.steer_x)
                $display("%0t: steer_x expected %h got %h", $time, e.steer_x, got.steer_x);
            if (got.steer_y !== e.steer_y)
                $display("%0t: steer_y expected %h got %h", $time, e.steer_y, got.steer_y);
            if (got !== e) errors++;
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [IN_W-1:0] s_tdata;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_wr_en;
    logic [1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    motion_scoreboard board;
    longint cycles;
    int stall_mode;
    logic finished;

    seek_steering_motion_step_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: stall pattern switches between none, periodic and random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= (cycles % 7) < 4;
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
        if ($urandom_range(0, 499) == 0) stall_mode <= int'($urandom_range(0, 2));
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000 && !finished) begin
            $display("seek_steering_motion_step_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_word(logic [3:0] keys, logic [15:0] dt);
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, dt, keys};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input({4'd0, dt, keys});
        // gap of random length between bursts
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [30:0] rand_reg();
        case ($urandom_range(0, 4))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(0, 32'h0100_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    initial begin
        board = new();
        board.reset_state();
        finished = 0;
        cycles = 0;
        stall_mode = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_addr = REG_MOVE_SPEED;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every key combination, zero and full step, cancelling keys
        for (int k = 0; k < 16; k++) send_word(k[3:0], 16'hFFFF);
        send_word(4'b0000, 16'd0);
        send_word(4'b0011, 16'd1);
        send_word(4'b1100, 16'h8000);
        send_word(4'b1111, 16'hFFFF);
        send_word(4'b1001, 16'd0);
        drain();

        // extremes: huge speed and limits drive saturation of velocity and position
        write_reg(REG_MOVE_SPEED, 31'h7FFF_FFFF);
        write_reg(REG_MAX_VELOCITY, 31'h7FFF_FFFF);
        write_reg(REG_MAX_STEERING, 31'h7FFF_FFFF);
        for (int i = 0; i < 12; i++) send_word(4'($urandom), 16'hFFFF);
        drain();
        write_reg(REG_MAX_STEERING, 31'd0);
        write_reg(REG_MOVE_SPEED, 31'd0);
        for (int i = 0; i < 4; i++) send_word(4'($urandom), rand_dt());
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            write_reg(REG_MOVE_SPEED, rand_reg());
            write_reg(REG_MAX_VELOCITY, rand_reg());
            write_reg(REG_MAX_STEERING, rand_reg());
            for (int i = 0; i < 80; i++) send_word(4'($urandom), rand_dt());
            drain();
        end

        finished = 1;
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("seek_steering_motion_step_core_tb: done, clean");
        end else begin
            $display("seek_steering_motion_step_core_tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
